@@ hw/rtl/stack_machine_execute_unit_macros.svh @@
// Assertion helpers shared by the execute unit modules.
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SMEU_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smeu assertion failed");
// Next-cycle implication, disabled during reset.
`define SMEU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smeu assertion failed");
`else
`define SMEU_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define SMEU_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/smeu_pkg.sv @@
package smeu_pkg;

    // Fixed field widths.
    localparam int DW        = 32;
    localparam int AW        = 8;
    localparam int MEM_WORDS = 256;
    localparam int LW        = 16;

    // Opcodes.
    localparam logic [3:0] OP_LD  = 4'd0;
    localparam logic [3:0] OP_ST  = 4'd1;
    localparam logic [3:0] OP_LBL = 4'd2;
    localparam logic [3:0] OP_BR  = 4'd3;
    localparam logic [3:0] OP_JMP = 4'd4;
    localparam logic [3:0] OP_LDC = 4'd5;
    localparam logic [3:0] OP_SUB = 4'd6;
    localparam logic [3:0] OP_ADD = 4'd7;
    localparam logic [3:0] OP_MUL = 4'd8;
    localparam logic [3:0] OP_MOD = 4'd9;
    localparam logic [3:0] OP_DIV = 4'd10;
    localparam logic [3:0] OP_CMP = 4'd11;

    localparam logic EXT_HALT = 1'b1;

    // Status codes.
    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_MISSING = 3'd1;
    localparam logic [2:0] STS_NOLABEL = 3'd2;
    localparam logic [2:0] STS_HALTEMP = 3'd3;
    localparam logic [2:0] STS_OVERFLW = 3'd4;
    localparam logic [2:0] STS_DIVZERO = 3'd5;
    localparam logic [2:0] STS_STOPPED = 3'd6;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic fetch;
        logic exec;
        logic div_commit;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_sts;

endpackage

@@ hw/rtl/smeu_div.sv @@
module smeu_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [smeu_pkg::DW-1:0] i_dividend,
    input  logic [smeu_pkg::DW-1:0] i_divisor,
    output logic                  o_done,
    output logic [smeu_pkg::DW-1:0] o_quotient,
    output logic [smeu_pkg::DW-1:0] o_remainder
);
    import smeu_pkg::*;

    localparam int CW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_dvs;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;

    // One restoring step per cycle.
    assign w_sh   = {r_rem, r_quo[DW-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DW]) begin
                r_rem <= w_diff[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ hw/rtl/smeu_datapath.sv @@
`include "stack_machine_execute_unit_macros.svh"

module smeu_datapath #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  smeu_pkg::t_cmd               i_cmd,
    output smeu_pkg::t_sts               o_sts,
    input  logic [3:0]                   i_mode,
    input  logic                         i_opcode_ext,
    input  logic [smeu_pkg::AW-1:0]      i_mem_address,
    input  logic signed [smeu_pkg::DW-1:0] i_constant_value,
    input  logic                         i_label_found,
    input  logic [smeu_pkg::LW-1:0]      i_source_line,
    output logic [2:0]                   o_status,
    output logic                         o_branch_taken,
    output logic                         o_halted,
    output logic                         o_halt_value_valid,
    output logic signed [smeu_pkg::DW-1:0] o_halt_value,
    output logic [smeu_pkg::LW-1:0]      o_error_line
);
    import smeu_pkg::*;

    localparam int SW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DPW = $clog2(STACK_DEPTH + 1);
    localparam logic [DPW-1:0] DEPTH_MAX = DPW'(STACK_DEPTH);

    // Captured instruction.
    logic [3:0]    r_mode;
    logic          r_ext;
    logic [AW-1:0] r_addr;
    logic [DW-1:0] r_cval;
    logic          r_found;
    logic [LW-1:0] r_line;

    // Architectural state.
    logic [DPW-1:0] r_depth;
    logic           r_err;
    logic           r_stopped;
    logic [DW-1:0]  r_stack [STACK_DEPTH];
    logic [DW-1:0]  r_dmem [MEM_WORDS];
    logic           r_dvld [MEM_WORDS];

    // Operands fetched from the memories.
    logic [DW-1:0] r_top;
    logic [DW-1:0] r_nxt;
    logic [DW-1:0] r_mem_rd;
    logic          r_mem_rd_vld;

    // Divide bookkeeping.
    logic r_neg_q;
    logic r_neg_r;

    // Result registers.
    logic [2:0]    r_out_status;
    logic          r_out_taken;
    logic          r_out_halted;
    logic          r_out_hvalid;
    logic [DW-1:0] r_out_hval;
    logic [LW-1:0] r_out_line;

    logic [DPW-1:0] w_dm1;
    logic [DPW-1:0] w_dm2;
    logic [DPW-1:0] w_base;
    logic [DW-1:0]  w_mem_val;
    logic [DW-1:0]  w_prod;
    logic [DW-1:0]  w_mag_a;
    logic [DW-1:0]  w_mag_b;
    logic [DW-1:0]  w_quo;
    logic [DW-1:0]  w_rem;
    logic [DW-1:0]  w_div_res;
    logic           w_div_done;
    logic           w_div_start;

    logic [1:0]    w_pop;
    logic          w_push;
    logic [DW-1:0] w_push_val;
    logic          w_mem_wr;
    logic          w_need_div;
    logic [2:0]    w_status;
    logic          w_taken;
    logic          w_halt;
    logic          w_hvalid;
    logic [DW-1:0] w_hval;

    assign w_dm1     = r_depth - DPW'(1);
    assign w_dm2     = r_depth - DPW'(2);
    assign w_mem_val = r_mem_rd_vld ? r_mem_rd : '0;
    assign w_prod    = r_nxt * r_top;
    assign w_mag_a   = r_nxt[DW-1] ? (DW'(0) - r_nxt) : r_nxt;
    assign w_mag_b   = r_top[DW-1] ? (DW'(0) - r_top) : r_top;

    // Instruction capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_ext   <= i_opcode_ext;
            r_addr  <= i_mem_address;
            r_cval  <= i_constant_value;
            r_found <= i_label_found;
            r_line  <= i_source_line;
        end
    end

    // Execute decode: what this instruction pops, pushes and reports.
    always_comb begin
        w_pop      = 2'd0;
        w_push     = 1'b0;
        w_push_val = '0;
        w_mem_wr   = 1'b0;
        w_need_div = 1'b0;
        w_status   = STS_OK;
        w_taken    = 1'b0;
        w_halt     = 1'b0;
        w_hvalid   = 1'b0;
        w_hval     = '0;
        if (r_stopped) begin
            w_status = STS_STOPPED;
        end else begin
            case (r_mode)
                OP_LD: begin
                    if (r_depth == DEPTH_MAX) begin
                        w_status = STS_OVERFLW;
                    end else begin
                        w_push     = 1'b1;
                        w_push_val = w_mem_val;
                    end
                end
                OP_ST: begin
                    if (r_depth == '0) begin
                        w_status = STS_MISSING;
                    end else begin
                        w_pop    = 2'd1;
                        w_mem_wr = 1'b1;
                    end
                end
                OP_LBL: begin
                end
                OP_BR: begin
                    if (r_depth == '0) begin
                        w_status = STS_MISSING;
                        w_halt   = 1'b1;
                    end else begin
                        w_pop = 2'd1;
                        if (r_top != '0) begin
                            if (r_found) begin
                                w_taken = 1'b1;
                            end else begin
                                w_status = STS_NOLABEL;
                                w_halt   = 1'b1;
                            end
                        end
                    end
                end
                OP_JMP: begin
                    if (r_found) begin
                        w_taken = 1'b1;
                    end else begin
                        w_status = STS_NOLABEL;
                        w_halt   = 1'b1;
                    end
                end
                OP_LDC: begin
                    if (r_depth == DEPTH_MAX) begin
                        w_status = STS_OVERFLW;
                    end else begin
                        w_push     = 1'b1;
                        w_push_val = r_cval;
                    end
                end
                OP_SUB, OP_ADD, OP_MUL, OP_MOD, OP_DIV, OP_CMP: begin
                    if (r_mode == OP_CMP && r_ext == EXT_HALT) begin
                        // Halt pops the result unless an error came first.
                        w_halt = 1'b1;
                        if (r_depth == '0) begin
                            w_status = STS_HALTEMP;
                        end else if (!r_err) begin
                            w_pop    = 2'd1;
                            w_hvalid = 1'b1;
                            w_hval   = r_top;
                        end
                    end else if (r_depth == '0) begin
                        w_status = STS_MISSING;
                    end else if (r_depth == DPW'(1)) begin
                        // The lone operand is dropped.
                        w_status = STS_MISSING;
                        w_pop    = 2'd1;
                    end else begin
                        w_pop = 2'd2;
                        case (r_mode)
                            OP_SUB: begin
                                w_push     = 1'b1;
                                w_push_val = r_nxt - r_top;
                            end
                            OP_ADD: begin
                                w_push     = 1'b1;
                                w_push_val = r_nxt + r_top;
                            end
                            OP_MUL: begin
                                w_push     = 1'b1;
                                w_push_val = w_prod;
                            end
                            OP_MOD, OP_DIV: begin
                                if (w_mag_b == '0) begin
                                    w_status = STS_DIVZERO;
                                    w_push   = 1'b1;
                                end else begin
                                    w_need_div = 1'b1;
                                end
                            end
                            default: begin
                                w_push = 1'b1;
                                if ($signed(r_nxt) > $signed(r_top)) begin
                                    w_push_val = DW'(1);
                                end else if ($signed(r_nxt) < $signed(r_top)) begin
                                    w_push_val = '1;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    w_halt = 1'b1;
                end
            endcase
        end
    end

    assign w_base      = r_depth - DPW'(w_pop);
    assign w_div_start = i_cmd.exec && w_need_div;

    // Iterative divider on magnitudes.
    smeu_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_mag_a),
        .i_divisor   (w_mag_b),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // Sign fixup of the divider result.
    always_comb begin
        if (r_mode == OP_MOD) begin
            w_div_res = r_neg_r ? (DW'(0) - w_rem) : w_rem;
        end else begin
            w_div_res = r_neg_q ? (DW'(0) - w_quo) : w_quo;
        end
    end

    // Operand stack: two registered reads, one write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_top <= r_stack[w_dm1[SW-1:0]];
            r_nxt <= r_stack[w_dm2[SW-1:0]];
        end
        if (i_cmd.exec && w_push) begin
            r_stack[w_base[SW-1:0]] <= w_push_val;
        end else if (i_cmd.div_commit) begin
            r_stack[r_depth[SW-1:0]] <= w_div_res;
        end
    end

    // Data memory array.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_mem_rd <= r_dmem[r_addr];
        end
        if (i_cmd.exec && w_mem_wr) begin
            r_dmem[r_addr] <= r_top;
        end
    end

    // Data memory written flags; an unwritten word reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MEM_WORDS; k++) begin
                r_dvld[k] <= 1'b0;
            end
            r_mem_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.fetch) begin
                r_mem_rd_vld <= r_dvld[r_addr];
            end
            if (i_cmd.exec && w_mem_wr) begin
                r_dvld[r_addr] <= 1'b1;
            end
        end
    end

    // Stack depth and machine flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_err     <= 1'b0;
            r_stopped <= 1'b0;
        end else if (i_cmd.exec) begin
            r_depth <= w_base + DPW'(w_push);
            if (w_status != STS_OK && w_status != STS_STOPPED) begin
                r_err <= 1'b1;
            end
            if (w_halt) begin
                r_stopped <= 1'b1;
            end
        end else if (i_cmd.div_commit) begin
            r_depth <= r_depth + DPW'(1);
        end
    end

    // Result registers and divide signs.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_status <= w_status;
            r_out_taken  <= w_taken;
            r_out_halted <= r_stopped || w_halt;
            r_out_hvalid <= w_hvalid;
            r_out_hval   <= w_hval;
            if (w_status == STS_MISSING || w_status == STS_NOLABEL ||
                w_status == STS_OVERFLW || w_status == STS_DIVZERO) begin
                r_out_line <= r_line;
            end else begin
                r_out_line <= '0;
            end
            r_neg_q <= r_nxt[DW-1] ^ r_top[DW-1];
            r_neg_r <= r_nxt[DW-1];
        end
    end

    assign o_sts.need_div   = w_need_div;
    assign o_sts.div_done   = w_div_done;
    assign o_status           = r_out_status;
    assign o_branch_taken     = r_out_taken;
    assign o_halted           = r_out_halted;
    assign o_halt_value_valid = r_out_hvalid;
    assign o_halt_value       = r_out_hval;
    assign o_error_line       = r_out_line;

    `SMEU_ASSERT_IMPL(a_depth_bound, i_clk, i_rst_n, 1'b1, r_depth <= DEPTH_MAX)
    `SMEU_ASSERT_NEXT(a_stopped_sticky, i_clk, i_rst_n, r_stopped, r_stopped)

endmodule

@@ hw/rtl/smeu_ctrl.sv @@
`include "stack_machine_execute_unit_macros.svh"

module smeu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output smeu_pkg::t_cmd o_cmd,
    input  smeu_pkg::t_sts i_sts
);
    import smeu_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_EXEC  = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_sts.need_div ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands to the datapath and handshake outputs.
    assign o_cmd.capture    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.fetch      = (r_state == S_FETCH);
    assign o_cmd.exec       = (r_state == S_EXEC);
    assign o_cmd.div_commit = (r_state == S_DIV) && i_sts.div_done;
    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = (r_state == S_OUT);

    `SMEU_ASSERT_NEXT(a_idle_accept, i_clk, i_rst_n, r_state == S_IDLE && i_in_valid, r_state == S_FETCH)
    `SMEU_ASSERT_NEXT(a_exec_div, i_clk, i_rst_n, r_state == S_EXEC && i_sts.need_div, r_state == S_DIV)
    `SMEU_ASSERT_NEXT(a_div_done, i_clk, i_rst_n, r_state == S_DIV && i_sts.div_done, r_state == S_OUT)

endmodule

@@ hw/rtl/stack_machine_execute_unit.sv @@
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_mode .. i_source_line
// result    out        o_out_valid / i_out_stall o_status .. o_error_line
//
// One instruction at a time: it is captured, fetched, executed and then presented.
// Divide and modulo with a nonzero divisor also wait for the bit-serial divider.
// Reset is synchronous and active low; it empties the stack and clears the data memory.
// The input is stalled from capture until the result transaction completes.
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [3:0]                    i_mode,
    input  logic                          i_opcode_ext,
    input  logic [smeu_pkg::AW-1:0]       i_mem_address,
    input  logic signed [smeu_pkg::DW-1:0] i_constant_value,
    input  logic                          i_label_found,
    input  logic [smeu_pkg::LW-1:0]       i_source_line,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_status,
    output logic                          o_branch_taken,
    output logic                          o_halted,
    output logic                          o_halt_value_valid,
    output logic signed [smeu_pkg::DW-1:0] o_halt_value,
    output logic [smeu_pkg::LW-1:0]       o_error_line
);
    import smeu_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    smeu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Stack, memory and arithmetic.
    smeu_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_mode             (i_mode),
        .i_opcode_ext       (i_opcode_ext),
        .i_mem_address      (i_mem_address),
        .i_constant_value   (i_constant_value),
        .i_label_found      (i_label_found),
        .i_source_line      (i_source_line),
        .o_status           (o_status),
        .o_branch_taken     (o_branch_taken),
        .o_halted           (o_halted),
        .o_halt_value_valid (o_halt_value_valid),
        .o_halt_value       (o_halt_value),
        .o_error_line       (o_error_line)
    );

endmodule

@@ test/tb_stack_machine_execute_unit.sv @@
`timescale 1ns / 1ps

module tb_stack_machine_execute_unit;
    import smeu_pkg::*;

    localparam int STACK_WORDS = 64;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT = 600000;

    // One instruction as presented on the input channel.
    typedef struct {
        logic [3:0]        mode;
        logic              ext;
        logic [AW-1:0]     addr;
        logic signed [DW-1:0] cval;
        logic              found;
        logic [LW-1:0]     line;
    } t_insn;

    // One result transaction.
    typedef struct {
        logic [2:0]        status;
        logic              taken;
        logic              halted;
        logic              hvalid;
        logic signed [DW-1:0] hval;
        logic [LW-1:0]     eline;
    } t_outcome;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [3:0]           i_mode = '0;
    logic                 i_opcode_ext = 1'b0;
    logic [AW-1:0]        i_mem_address = '0;
    logic signed [DW-1:0] i_constant_value = '0;
    logic                 i_label_found = 1'b0;
    logic [LW-1:0]        i_source_line = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [2:0]           o_status;
    logic                 o_branch_taken;
    logic                 o_halted;
    logic                 o_halt_value_valid;
    logic signed [DW-1:0] o_halt_value;
    logic [LW-1:0]        o_error_line;

    t_insn    insn_q[$];
    t_outcome expected_results_q[$];

    // Shadow machine state used to predict each result.
    logic [DW-1:0] shadow_mem[MEM_WORDS];
    logic [DW-1:0] shadow_stack[STACK_WORDS];
    int            shadow_depth;
    bit            shadow_error;
    bit            shadow_stopped;

    int  fail_cnt = 0;
    int  checked_cnt = 0;
    int  cycle_cnt = 0;
    int  send_gap = 0;
    int  stall_cnt = 0;
    bit  send_burst = 1'b0;
    bit  recv_burst = 1'b0;
    bit  clean_run;
    int  stop_kind;

    stack_machine_execute_unit #(
        .STACK_DEPTH(STACK_WORDS)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_mode             (i_mode),
        .i_opcode_ext       (i_opcode_ext),
        .i_mem_address      (i_mem_address),
        .i_constant_value   (i_constant_value),
        .i_label_found      (i_label_found),
        .i_source_line      (i_source_line),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_branch_taken     (o_branch_taken),
        .o_halted           (o_halted),
        .o_halt_value_valid (o_halt_value_valid),
        .o_halt_value       (o_halt_value),
        .o_error_line       (o_error_line)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Executes one instruction on the shadow state and returns its result.
    function automatic t_outcome execute_insn(t_insn it);
        t_outcome      r;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic [DW-1:0] ma;
        logic [DW-1:0] mb;
        logic [DW-1:0] res;
        bit            halt_now;
        r = '{default: '0};
        halt_now = 1'b0;
        if (shadow_stopped) begin
            r.status = STS_STOPPED;
        end else begin
            case (it.mode)
                OP_LD, OP_LDC: begin
                    if (shadow_depth >= STACK_WORDS) begin
                        r.status = STS_OVERFLW;
                    end else begin
                        shadow_stack[shadow_depth] = (it.mode == OP_LD) ?
                            shadow_mem[it.addr] : it.cval;
                        shadow_depth++;
                    end
                end
                OP_ST: begin
                    if (shadow_depth == 0) begin
                        r.status = STS_MISSING;
                    end else begin
                        shadow_depth--;
                        shadow_mem[it.addr] = shadow_stack[shadow_depth];
                    end
                end
                OP_LBL: ;
                OP_BR: begin
                    if (shadow_depth == 0) begin
                        r.status = STS_MISSING;
                        halt_now = 1'b1;
                    end else begin
                        shadow_depth--;
                        if (shadow_stack[shadow_depth] != 0) begin
                            if (it.found) begin
                                r.taken = 1'b1;
                            end else begin
                                r.status = STS_NOLABEL;
                                halt_now = 1'b1;
                            end
                        end
                    end
                end
                OP_JMP: begin
                    if (it.found) begin
                        r.taken = 1'b1;
                    end else begin
                        r.status = STS_NOLABEL;
                        halt_now = 1'b1;
                    end
                end
                OP_SUB, OP_ADD, OP_MUL, OP_MOD, OP_DIV, OP_CMP: begin
                    if (it.mode == OP_CMP && it.ext == EXT_HALT) begin
                        halt_now = 1'b1;
                        if (shadow_depth == 0) begin
                            r.status = STS_HALTEMP;
                        end else if (!shadow_error) begin
                            shadow_depth--;
                            r.hval = shadow_stack[shadow_depth];
                            r.hvalid = 1'b1;
                        end
                    end else if (shadow_depth == 0) begin
                        r.status = STS_MISSING;
                    end else begin
                        shadow_depth--;
                        b = shadow_stack[shadow_depth];
                        if (shadow_depth == 0) begin
                            r.status = STS_MISSING;
                        end else begin
                            shadow_depth--;
                            a = shadow_stack[shadow_depth];
                            ma = a[DW-1] ? -a : a;
                            mb = b[DW-1] ? -b : b;
                            res = '0;
                            case (it.mode)
                                OP_SUB: res = a - b;
                                OP_ADD: res = a + b;
                                OP_MUL: res = a * b;
                                OP_DIV, OP_MOD: begin
                                    // Signed division truncates toward zero on magnitudes.
                                    if (mb == 0) begin
                                        r.status = STS_DIVZERO;
                                    end else if (it.mode == OP_DIV) begin
                                        res = (a[DW-1] ^ b[DW-1]) ? -(ma / mb) : (ma / mb);
                                    end else begin
                                        res = a[DW-1] ? -(ma % mb) : (ma % mb);
                                    end
                                end
                                default: begin
                                    if ($signed(a) > $signed(b)) res = 1;
                                    else if ($signed(a) < $signed(b)) res = '1;
                                end
                            endcase
                            shadow_stack[shadow_depth] = res;
                            shadow_depth++;
                        end
                    end
                end
                default: halt_now = 1'b1;
            endcase
            if (r.status != STS_OK) shadow_error = 1'b1;
            if (halt_now) shadow_stopped = 1'b1;
        end
        r.halted = shadow_stopped;
        if (r.status != STS_OK && r.status != STS_HALTEMP && r.status != STS_STOPPED)
            r.eline = it.line;
        return r;
    endfunction

    // Queues one instruction together with its predicted result.
    task automatic put(logic [3:0] mode, logic ext, logic [AW-1:0] addr,
                       logic signed [DW-1:0] cval, logic found);
        t_insn it;
        it.mode = mode;
        it.ext = ext;
        it.addr = addr;
        it.cval = cval;
        it.found = found;
        it.line = LW'($urandom);
        insn_q.push_back(it);
        expected_results_q.push_back(execute_insn(it));
    endtask

    function automatic logic [DW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return '1;
            3: return 32'h7fff_ffff;
            4: return 32'h8000_0000;
            5: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // Draws one well-formed instruction from the current shadow state.
    task automatic put_random();
        int            pick;
        logic [3:0]    mode;
        logic [DW-1:0] top;
        pick = $urandom_range(0, 99);
        if (shadow_depth > 56 && pick < 40) pick = pick + 40;
        if (pick < 18) mode = OP_LDC;
        else if (pick < 35) mode = OP_LD;
        else if (pick < 45) mode = OP_ST;
        else if (pick < 53) mode = OP_BR;
        else if (pick < 57) mode = OP_JMP;
        else if (pick < 60) mode = OP_LBL;
        else mode = 4'($urandom_range(OP_SUB, OP_CMP));
        top = (shadow_depth > 0) ? shadow_stack[shadow_depth - 1] : '0;
        // A clean run must never raise an error.
        if (clean_run) begin
            if (mode >= OP_SUB && shadow_depth < 2) mode = OP_LDC;
            if ((mode == OP_DIV || mode == OP_MOD) && top == 0) mode = OP_ADD;
            if (mode == OP_ST && shadow_depth == 0) mode = OP_LDC;
            if ((mode == OP_LD || mode == OP_LDC) && shadow_depth >= STACK_WORDS)
                mode = OP_ADD;
        end
        if (mode == OP_BR && shadow_depth == 0) mode = OP_LDC;
        if (mode == OP_BR && top != 0) begin
            put(mode, 1'($urandom), AW'($urandom), $urandom, 1'b1);
        end else if (mode == OP_JMP) begin
            put(mode, 1'($urandom), AW'($urandom), $urandom, 1'b1);
        end else if (mode == OP_CMP) begin
            put(mode, 1'b0, AW'($urandom), $urandom, 1'($urandom));
        end else begin
            put(mode, 1'($urandom), AW'($urandom), pick_value(), 1'($urandom));
        end
    endtask

    task automatic drain_stack();
        while (shadow_depth > 0)
            put(OP_ST, 1'($urandom), AW'($urandom), $urandom, 1'($urandom));
    endtask

    // Stimulus and end of run.
    initial begin
        int n;
        for (int k = 0; k < MEM_WORDS; k++) shadow_mem[k] = '0;
        for (int k = 0; k < STACK_WORDS; k++) shadow_stack[k] = '0;
        shadow_depth = 0;
        shadow_error = 1'b0;
        shadow_stopped = 1'b0;
        clean_run = ($urandom_range(0, 3) == 0);

        // Directed part: extremes, wrap cases and every operation.
        put(OP_LD, 1'b0, 8'd0, 0, 1'b0);
        put(OP_LDC, 1'b1, 8'd3, 32'sh7fff_ffff, 1'b0);
        put(OP_LDC, 1'b0, 8'd9, 1, 1'b1);
        put(OP_ADD, 1'b1, 8'd0, 0, 1'b0);
        put(OP_ST, 1'b0, 8'd255, 0, 1'b0);
        put(OP_LD, 1'b0, 8'd255, 0, 1'b0);
        put(OP_LDC, 1'b0, 8'd0, -1, 1'b0);
        put(OP_DIV, 1'b0, 8'd0, 0, 1'b0);
        put(OP_LD, 1'b0, 8'd255, 0, 1'b0);
        put(OP_LDC, 1'b0, 8'd0, -1, 1'b0);
        put(OP_MOD, 1'b1, 8'd0, 0, 1'b0);
        put(OP_LDC, 1'b0, 8'd0, -7, 1'b0);
        put(OP_LDC, 1'b0, 8'd0, 2, 1'b0);
        put(OP_MOD, 1'b0, 8'd0, 0, 1'b0);
        put(OP_CMP, 1'b0, 8'd0, 0, 1'b0);
        put(OP_MUL, 1'b0, 8'd0, 0, 1'b0);
        put(OP_SUB, 1'b0, 8'd0, 0, 1'b0);
        put(OP_LDC, 1'b0, 8'd0, 0, 1'b0);
        put(OP_BR, 1'b0, 8'd0, 0, 1'b0);
        put(OP_LDC, 1'b0, 8'd0, 5, 1'b0);
        put(OP_BR, 1'b0, 8'd0, 0, 1'b1);
        put(OP_JMP, 1'b0, 8'd0, 0, 1'b1);
        put(OP_LBL, 1'b1, 8'd0, 0, 1'b0);
        if (!clean_run) begin
            put(OP_LDC, 1'b0, 8'd0, 5, 1'b0);
            put(OP_LDC, 1'b0, 8'd0, 0, 1'b0);
            put(OP_DIV, 1'b0, 8'd0, 0, 1'b0);
            drain_stack();
            put(OP_ST, 1'b0, 8'd1, 0, 1'b0);
            put(OP_ADD, 1'b0, 8'd0, 0, 1'b0);
            put(OP_LDC, 1'b0, 8'd0, 9, 1'b0);
            put(OP_SUB, 1'b0, 8'd0, 0, 1'b0);
        end

        // Random programs, with occasional runs of pushes past a full stack.
        n = 0;
        while (n < RANDOM_ITEMS) begin
            if (!clean_run && $urandom_range(0, 299) == 0) begin
                repeat (STACK_WORDS + 4) begin
                    put(OP_LDC, 1'($urandom), AW'($urandom), pick_value(), 1'($urandom));
                    n++;
                end
            end else begin
                put_random();
                n++;
            end
        end

        // One instruction that stops the machine, then a few that find it stopped.
        stop_kind = clean_run ? 0 : $urandom_range(0, 5);
        case (stop_kind)
            0: begin
                put(OP_LDC, 1'b0, AW'($urandom), pick_value(), 1'b0);
                put(OP_CMP, EXT_HALT, AW'($urandom), $urandom, 1'($urandom));
            end
            1: begin
                drain_stack();
                put(OP_CMP, EXT_HALT, AW'($urandom), $urandom, 1'($urandom));
            end
            2: put(4'($urandom_range(12, 15)), 1'($urandom), AW'($urandom), $urandom,
                   1'($urandom));
            3: begin
                drain_stack();
                put(OP_BR, 1'b0, AW'($urandom), $urandom, 1'b1);
            end
            4: begin
                put(OP_LDC, 1'b0, AW'($urandom), 32'sd77, 1'b0);
                put(OP_BR, 1'b0, AW'($urandom), $urandom, 1'b0);
            end
            default: put(OP_JMP, 1'b0, AW'($urandom), $urandom, 1'b0);
        endcase
        repeat (12) put(4'($urandom_range(0, 15)), 1'($urandom), AW'($urandom), $urandom,
                        1'($urandom));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (insn_q.size() != 0 || expected_results_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Checked %0d results; %s run, stopping case %0d.", checked_cnt,
                 clean_run ? "error-free" : "error-injecting", stop_kind);
        if (fail_cnt == 0) begin
            $display("stack_machine_execute_unit verification clean");
        end else begin
            $display("stack_machine_execute_unit verification failed");
        end
        $finish;
    end

    // Input driver: holds a stalled transaction, otherwise waits its gap and sends the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap <= 0;
        end else if (i_in_valid && o_in_stall) begin
            // Payload stays put while stalled.
        end else if (send_gap != 0) begin
            i_in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (insn_q.size() != 0) begin
            i_mode <= insn_q[0].mode;
            i_opcode_ext <= insn_q[0].ext;
            i_mem_address <= insn_q[0].addr;
            i_constant_value <= insn_q[0].cval;
            i_label_found <= insn_q[0].found;
            i_source_line <= insn_q[0].line;
            void'(insn_q.pop_front());
            i_in_valid <= 1'b1;
            if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
            send_gap <= send_burst ? 0 : $urandom_range(0, 10);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Result monitor and stall generator.
    always @(posedge i_clk) begin
        t_outcome e;
        int       wait_n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results_q.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    fail_cnt++;
                end else begin
                    e = expected_results_q.pop_front();
                    checked_cnt++;
                    if (o_status !== e.status) begin
                        $error("status: expected %0d, actual %0d", e.status, o_status);
                        fail_cnt++;
                    end
                    if (o_branch_taken !== e.taken) begin
                        $error("branch_taken: expected %0d, actual %0d", e.taken,
                               o_branch_taken);
                        fail_cnt++;
                    end
                    if (o_halted !== e.halted) begin
                        $error("halted: expected %0d, actual %0d", e.halted, o_halted);
                        fail_cnt++;
                    end
                    if (o_halt_value_valid !== e.hvalid) begin
                        $error("halt_value_valid: expected %0d, actual %0d", e.hvalid,
                               o_halt_value_valid);
                        fail_cnt++;
                    end
                    if (o_halt_value !== e.hval) begin
                        $error("halt_value: expected %0d, actual %0d", e.hval, o_halt_value);
                        fail_cnt++;
                    end
                    if (o_error_line !== e.eline) begin
                        $error("error_line: expected %0d, actual %0d", e.eline, o_error_line);
                        fail_cnt++;
                    end
                end
                if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
                wait_n = recv_burst ? 0 : $urandom_range(0, 10);
                stall_cnt <= wait_n;
                i_out_stall <= (wait_n != 0);
            end else if (stall_cnt != 0) begin
                stall_cnt <= stall_cnt - 1;
                i_out_stall <= (stall_cnt > 1);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("stack_machine_execute_unit verification failed");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/smeu_pkg.sv
hw/rtl/smeu_div.sv
hw/rtl/smeu_datapath.sv
hw/rtl/smeu_ctrl.sv
hw/rtl/stack_machine_execute_unit.sv
test/tb_stack_machine_execute_unit.sv
